// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/pidci_pkg.sv -----
// ----------------------------------------------------------------------------
// pidci_pkg
// Types and constants shared by the PID controller blocks.
// ----------------------------------------------------------------------------
package pidci_pkg;

	// fixed field widths
	localparam int GAIN_W   = 16;
	localparam int ACCUM_W  = 32;
	localparam int DRIVE_W  = 32;
	localparam int DATA_W   = 32;
	localparam int CFG_ADDR_W = 5;

	// parameter defaults
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int SAMPLE_WIDTH_DEF   = 16;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_PRESET = 1'b1;

	// register map, word index
	typedef enum logic [2:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_TARGET_LEVEL = 3'd3,
		REG_INTEG_UPPER  = 3'd4,
		REG_INTEG_LOWER  = 3'd5
	} reg_idx_t;

	// gains and clamp limits
	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [ACCUM_W-1:0] integ_upper;
		logic [ACCUM_W-1:0] integ_lower;
	} cfg_t;

	// pipeline advance strobes
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
	} pipe_ctl_t;

endpackage

// ----- rtl/pidci_regs.sv -----
// ----------------------------------------------------------------------------
// pidci_regs
// APB register bank: gains, set point and integrator clamp limits.
// ----------------------------------------------------------------------------
module pidci_regs #(
	parameter int SAMPLE_WIDTH = pidci_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pidci_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [pidci_pkg::DATA_W-1:0]         pwdata,
	output logic [pidci_pkg::DATA_W-1:0]         prdata,
	output logic                                 pready,
	output pidci_pkg::cfg_t                      cfg,
	output logic signed [SAMPLE_WIDTH-1:0]       target_level
);
	import pidci_pkg::*;

	cfg_t                     cfg_q;
	logic [SAMPLE_WIDTH-1:0]  target_q;
	logic                     wr_en;
	reg_idx_t                 reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	// register writes; unmapped words are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			target_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PROP_GAIN:    cfg_q.prop_gain   <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:   cfg_q.integ_gain  <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:   cfg_q.deriv_gain  <= pwdata[GAIN_W-1:0];
				REG_TARGET_LEVEL: target_q          <= pwdata[SAMPLE_WIDTH-1:0];
				REG_INTEG_UPPER:  cfg_q.integ_upper <= pwdata[ACCUM_W-1:0];
				REG_INTEG_LOWER:  cfg_q.integ_lower <= pwdata[ACCUM_W-1:0];
				default: ;
			endcase
		end
	end

	// read-back, sign extended
	always_comb begin
		unique case (reg_idx)
			REG_PROP_GAIN:
				prdata = {{(DATA_W-GAIN_W){cfg_q.prop_gain[GAIN_W-1]}}, cfg_q.prop_gain};
			REG_INTEG_GAIN:
				prdata = {{(DATA_W-GAIN_W){cfg_q.integ_gain[GAIN_W-1]}}, cfg_q.integ_gain};
			REG_DERIV_GAIN:
				prdata = {{(DATA_W-GAIN_W){cfg_q.deriv_gain[GAIN_W-1]}}, cfg_q.deriv_gain};
			REG_TARGET_LEVEL:
				prdata = DATA_W'($signed(target_q));
			REG_INTEG_UPPER:  prdata = cfg_q.integ_upper;
			REG_INTEG_LOWER:  prdata = cfg_q.integ_lower;
			default:          prdata = '0;
		endcase
	end

	assign cfg          = cfg_q;
	assign target_level = $signed(target_q);

endmodule

// ----- rtl/pidci_core.sv -----
// ----------------------------------------------------------------------------
// pidci_core
// Error, derivative and clamped integrator update; registers the three
// gain products for the output stage.
// ----------------------------------------------------------------------------
module pidci_core #(
	parameter int SAMPLE_WIDTH = pidci_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pidci_pkg::pipe_ctl_t                   ctl,
	input  pidci_pkg::cfg_t                        cfg,
	input  logic signed [SAMPLE_WIDTH-1:0]         target_level,
	input  logic                                   req_type_s1,
	input  logic signed [SAMPLE_WIDTH-1:0]         meas_s1,
	input  logic signed [pidci_pkg::ACCUM_W-1:0]   preset_s1,
	output logic signed [SAMPLE_WIDTH+16:0]        prod_p_s2,
	output logic signed [pidci_pkg::ACCUM_W+15:0]  prod_i_s2,
	output logic signed [SAMPLE_WIDTH+17:0]        prod_d_s2,
	output logic signed [SAMPLE_WIDTH:0]           err_s2,
	output logic signed [pidci_pkg::ACCUM_W-1:0]   accum_s2,
	output logic signed [SAMPLE_WIDTH:0]           prev_s2
);
	import pidci_pkg::*;

	localparam int ERR_W   = SAMPLE_WIDTH + 1;
	localparam int DELTA_W = SAMPLE_WIDTH + 2;
	localparam int SUM_W   = ((ERR_W > ACCUM_W) ? ERR_W : ACCUM_W) + 1;

	// controller state
	logic signed [ACCUM_W-1:0] accum_q;
	logic signed [ERR_W-1:0]   prev_err_q;

	logic signed [GAIN_W-1:0]  kp, ki, kd;
	logic signed [ACCUM_W-1:0] upper, lower;
	logic signed [ERR_W-1:0]   err;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SUM_W-1:0]   acc_sum, upper_x, lower_x;
	logic signed [ACCUM_W-1:0] acc_next;
	logic signed [SAMPLE_WIDTH+16:0]  prod_p;
	logic signed [ACCUM_W+15:0]       prod_i;
	logic signed [SAMPLE_WIDTH+17:0]  prod_d;

	assign kp    = cfg.prop_gain;
	assign ki    = cfg.integ_gain;
	assign kd    = cfg.deriv_gain;
	assign upper = cfg.integ_upper;
	assign lower = cfg.integ_lower;

	// error and derivative
	assign err   = ERR_W'(target_level) - ERR_W'(meas_s1);
	assign delta = DELTA_W'(err) - DELTA_W'(prev_err_q);

	// integrate, then clamp: upper limit tested first
	assign acc_sum = SUM_W'(accum_q) + SUM_W'(err);
	assign upper_x = SUM_W'(upper);
	assign lower_x = SUM_W'(lower);

	always_comb begin
		if (acc_sum > upper_x) begin
			acc_next = upper;
		end else if (acc_sum < lower_x) begin
			acc_next = lower;
		end else begin
			acc_next = acc_sum[ACCUM_W-1:0];
		end
	end

	// gain products, exact width
	assign prod_p = kp * err;
	assign prod_i = ki * acc_next;
	assign prod_d = kd * delta;

	// state update as the item leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= '0;
			prev_err_q <= '0;
		end else if (ctl.adv_s1) begin
			if (req_type_s1 == REQ_PRESET) begin
				accum_q <= preset_s1;
			end else begin
				accum_q    <= acc_next;
				prev_err_q <= err;
			end
		end
	end

	// stage two payload; a preset carries zero products
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			if (req_type_s1 == REQ_PRESET) begin
				prod_p_s2 <= '0;
				prod_i_s2 <= '0;
				prod_d_s2 <= '0;
				err_s2    <= '0;
				accum_s2  <= preset_s1;
				prev_s2   <= prev_err_q;
			end else begin
				prod_p_s2 <= prod_p;
				prod_i_s2 <= prod_i;
				prod_d_s2 <= prod_d;
				err_s2    <= err;
				accum_s2  <= acc_next;
				prev_s2   <= err;
			end
		end
	end

endmodule

// ----- rtl/pidci_out.sv -----
// ----------------------------------------------------------------------------
// pidci_out
// Sums the gain products, drops the gain fraction bits and saturates the
// drive to 32 bits; holds the result register.
// ----------------------------------------------------------------------------
module pidci_out #(
	parameter int GAIN_FRAC_BITS = pidci_pkg::GAIN_FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH   = pidci_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  pidci_pkg::pipe_ctl_t                   ctl,
	input  logic signed [SAMPLE_WIDTH+16:0]        prod_p_s2,
	input  logic signed [pidci_pkg::ACCUM_W+15:0]  prod_i_s2,
	input  logic signed [SAMPLE_WIDTH+17:0]        prod_d_s2,
	input  logic signed [SAMPLE_WIDTH:0]           err_s2,
	input  logic signed [pidci_pkg::ACCUM_W-1:0]   accum_s2,
	input  logic signed [SAMPLE_WIDTH:0]           prev_s2,
	output logic signed [pidci_pkg::DRIVE_W-1:0]   drive,
	output logic signed [SAMPLE_WIDTH:0]           error_now,
	output logic signed [pidci_pkg::ACCUM_W-1:0]   accum_now,
	output logic signed [SAMPLE_WIDTH:0]           last_error_now
);
	import pidci_pkg::*;

	localparam int PI_W  = ACCUM_W + GAIN_W;
	localparam int PD_W  = SAMPLE_WIDTH + 2 + GAIN_W;
	localparam int SUM_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

	localparam logic signed [SUM_W-1:0] DRV_MAX =
		{{(SUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] DRV_MIN =
		{{(SUM_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

	logic signed [SUM_W-1:0]   sum, scaled;
	logic signed [DRIVE_W-1:0] drive_sat;

	// exact sum, floor shift
	assign sum    = SUM_W'(prod_p_s2) + SUM_W'(prod_i_s2) + SUM_W'(prod_d_s2);
	assign scaled = sum >>> GAIN_FRAC_BITS;

	// saturate to signed 32 bits
	always_comb begin
		if (scaled > DRV_MAX) begin
			drive_sat = DRV_MAX[DRIVE_W-1:0];
		end else if (scaled < DRV_MIN) begin
			drive_sat = DRV_MIN[DRIVE_W-1:0];
		end else begin
			drive_sat = scaled[DRIVE_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			drive          <= drive_sat;
			error_now      <= err_s2;
			accum_now      <= accum_s2;
			last_error_now <= prev_s2;
		end
	end

endmodule

// ----- rtl/pid_controller_clamped_integrator.sv -----
// ----------------------------------------------------------------------------
// pid_controller_clamped_integrator
// Discrete PID controller with a clamped integrator and APB register bank.
// ----------------------------------------------------------------------------
// Takes one item per clock unless in_stall is high. The item passes three
// registers: stage one registers the item, stage two forms the error, the
// derivative, the clamped integrator and the three gain products, and the
// result register receives the summed, scaled and saturated drive. The
// integrator and previous error update as an item leaves stage one, so the
// next item sees them at once; that add-and-clamp loop sets the clock. A
// preset item loads the integrator unclamped and returns a zero drive and a
// zero error. Gains are signed with GAIN_FRAC_BITS fraction bits; the drive
// rounds toward minus infinity. Registers sit at byte address 4*index and
// are to be written only while no item is in flight, which the block itself
// does not enforce; pready is always high.
// ----------------------------------------------------------------------------
module pid_controller_clamped_integrator #(
	parameter int GAIN_FRAC_BITS = pidci_pkg::GAIN_FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH   = pidci_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [pidci_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [pidci_pkg::DATA_W-1:0]           pwdata,
	output logic [pidci_pkg::DATA_W-1:0]           prdata,
	output logic                                   pready,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic signed [SAMPLE_WIDTH-1:0]         measurement,
	input  logic signed [pidci_pkg::ACCUM_W-1:0]   preset_value,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [pidci_pkg::DRIVE_W-1:0]   drive,
	output logic signed [SAMPLE_WIDTH:0]           error_now,
	output logic signed [pidci_pkg::ACCUM_W-1:0]   accum_now,
	output logic signed [SAMPLE_WIDTH:0]           last_error_now
);
	import pidci_pkg::*;

	cfg_t                            cfg;
	logic signed [SAMPLE_WIDTH-1:0]  target_level;
	pipe_ctl_t                       ctl;

	logic                            valid_s1, valid_s2, out_valid_q;
	logic                            req_type_s1;
	logic signed [SAMPLE_WIDTH-1:0]  meas_s1;
	logic signed [ACCUM_W-1:0]       preset_s1;
	logic                            out_free, s2_free, s1_free;

	logic signed [SAMPLE_WIDTH+16:0] prod_p_s2;
	logic signed [ACCUM_W+15:0]      prod_i_s2;
	logic signed [SAMPLE_WIDTH+17:0] prod_d_s2;
	logic signed [SAMPLE_WIDTH:0]    err_s2;
	logic signed [ACCUM_W-1:0]       accum_s2;
	logic signed [SAMPLE_WIDTH:0]    prev_s2;

	// register bank
	pidci_regs #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cfg          (cfg),
		.target_level (target_level)
	);

	// stage flow: a stage moves when the one after it is empty or moving
	assign out_free   = !out_valid_q || !out_stall;
	assign s2_free    = !valid_s2 || out_free;
	assign s1_free    = !valid_s1 || s2_free;
	assign ctl.adv_s1 = valid_s1 && s2_free;
	assign ctl.adv_s2 = valid_s2 && out_free;
	assign in_stall   = !s1_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			req_type_s1 <= req_type;
			meas_s1     <= measurement;
			preset_s1   <= preset_value;
		end
	end

	pidci_core #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg),
		.target_level (target_level),
		.req_type_s1  (req_type_s1),
		.meas_s1      (meas_s1),
		.preset_s1    (preset_s1),
		.prod_p_s2    (prod_p_s2),
		.prod_i_s2    (prod_i_s2),
		.prod_d_s2    (prod_d_s2),
		.err_s2       (err_s2),
		.accum_s2     (accum_s2),
		.prev_s2      (prev_s2)
	);

	pidci_out #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH)
	) u_out (
		.clk            (clk),
		.ctl            (ctl),
		.prod_p_s2      (prod_p_s2),
		.prod_i_s2      (prod_i_s2),
		.prod_d_s2      (prod_d_s2),
		.err_s2         (err_s2),
		.accum_s2       (accum_s2),
		.prev_s2        (prev_s2),
		.drive          (drive),
		.error_now      (error_now),
		.accum_now      (accum_now),
		.last_error_now (last_error_now)
	);

endmodule

// ----- rtl/pidci_checker.sv -----
// ----------------------------------------------------------------------------
// pidci_checker
// Port-level checks on the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidci_checker #(
	parameter int SAMPLE_WIDTH = pidci_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_stall,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic signed [pidci_pkg::DRIVE_W-1:0]   drive,
	input  logic signed [SAMPLE_WIDTH:0]           error_now,
	input  logic signed [pidci_pkg::ACCUM_W-1:0]   accum_now,
	input  logic signed [SAMPLE_WIDTH:0]           last_error_now
);

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a stalled result keeps its value
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(drive) && $stable(accum_now))

	// input backpressure only comes from a full pipe behind a waiting result
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// a sample with nonzero error stores that error as the previous one
	`ASSERT_IMPLIES(a_prev_err, clk, arst_n, out_valid && (error_now != '0), last_error_now == error_now)

endmodule

bind pid_controller_clamped_integrator pidci_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_pidci_checker (.*);
